// File: sv/phd_pkg.sv
package phd_pkg;

    // Width of the number under test.
    localparam int NUM_WIDTH   = 20;
    // Divisor count register; holds the count of any number below 2^32.
    localparam int CNT_W       = 12;
    // Sum of all divisors stays below eight times the number.
    localparam int SIG_W       = NUM_WIDTH + 3;
    // Candidate divisor, which runs up to one past the square root.
    localparam int D_W         = NUM_WIDTH / 2 + 2;
    // Square of the candidate.
    localparam int SQ_W        = NUM_WIDTH + 2;
    // Product of the number and its divisor count.
    localparam int PROD_W      = NUM_WIDTH + CNT_W;
    localparam int STEP_W      = $clog2(PROD_W);

    localparam int COUNT_OUT_W = 8;
    localparam int SUM_OUT_W   = 24;
    localparam logic [31:0] COUNT_MAX = 32'd255;
    localparam logic [31:0] SUM_MAX   = 32'd16777215;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_DWAIT,
        S_MUL,
        S_MOD,
        S_MWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_cand;
        logic div_mod;
        logic step;
        logic mul;
        logic cap_harm;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic sq_gt_n;
        logic div_busy;
        logic div_done;
    } t_dp_stat;

endpackage

// File: sv/phd_div.sv
module phd_div
    import phd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [SIG_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quo,
    output logic [SIG_W-1:0]  o_rem
);

    // Restoring divider, one quotient bit per cycle, MSB first.
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [SIG_W-1:0]  r_rem, n_rem;
    logic [SIG_W-1:0]  r_dvs, n_dvs;
    logic [SIG_W:0]    shifted;
    logic              ge;

    always_comb begin
        shifted = {r_rem, r_quo[PROD_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = r_done;
        n_step  = r_step;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_step = STEP_W'(PROD_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[PROD_W-2:0], ge};
            n_rem = ge ? SIG_W'(shifted - {1'b0, r_dvs}) : shifted[SIG_W-1:0];
            n_step = r_step - 1'b1;
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == '0 && !i_start) |=> r_done)
        else $error("divider missed its final step");
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("divider did not start");
`endif

endmodule

// File: sv/phd_dp.sv
module phd_dp
    import phd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [NUM_WIDTH-1:0]   i_num,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic                   o_is_perfect,
    output logic                   o_is_harmonic,
    output logic [COUNT_OUT_W-1:0] o_divisor_count,
    output logic [SUM_OUT_W-1:0]   o_proper_divisor_sum,
    output logic                   o_input_invalid
);

    logic [NUM_WIDTH-1:0]   r_n;
    logic [D_W-1:0]         r_d;
    logic [SQ_W-1:0]        r_sq;
    logic [CNT_W-1:0]       r_count;
    logic [SIG_W-1:0]       r_sigma;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_harm;
    logic                   r_perfect, r_harmonic, r_invalid;
    logic [COUNT_OUT_W-1:0] r_count_out;
    logic [SUM_OUT_W-1:0]   r_sum_out;

    logic                   div_start, div_busy, div_done;
    logic [PROD_W-1:0]      div_dividend, div_quo;
    logic [SIG_W-1:0]       div_divisor, div_rem;
    logic [NUM_WIDTH-1:0]   cofactor;
    logic                   pair;
    logic [SIG_W-1:0]       proper;

    assign div_start    = i_cmd.div_cand || i_cmd.div_mod;
    assign div_dividend = i_cmd.div_mod ? r_prod  : PROD_W'(r_n);
    assign div_divisor  = i_cmd.div_mod ? r_sigma : SIG_W'(r_d);

    phd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // The cofactor is a second divisor unless the candidate is the exact root.
    assign cofactor = div_quo[NUM_WIDTH-1:0];
    assign pair     = cofactor != NUM_WIDTH'(r_d);
    assign proper   = r_sigma - SIG_W'(r_n);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n     <= i_num;
            r_d     <= D_W'(1);
            r_sq    <= SQ_W'(1);
            r_count <= '0;
            r_sigma <= '0;
        end
        if (i_cmd.step) begin
            if (div_rem == '0) begin
                r_count <= r_count + (pair ? CNT_W'(2) : CNT_W'(1));
                r_sigma <= r_sigma + SIG_W'(r_d) + (pair ? SIG_W'(cofactor) : SIG_W'(0));
            end
            r_sq <= r_sq + SQ_W'({r_d, 1'b1});
            r_d  <= r_d + 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_n) * PROD_W'(r_count);
        end
        if (i_cmd.cap_harm) begin
            r_harm <= div_rem == '0;
        end
        if (i_cmd.out_load) begin
            if (r_n == '0) begin
                r_perfect   <= 1'b0;
                r_harmonic  <= 1'b0;
                r_invalid   <= 1'b1;
                r_count_out <= '0;
                r_sum_out   <= '0;
            end else begin
                r_perfect   <= proper == SIG_W'(r_n);
                r_harmonic  <= r_harm;
                r_invalid   <= 1'b0;
                r_count_out <= (32'(r_count) > COUNT_MAX) ? COUNT_OUT_W'(COUNT_MAX)
                                                          : COUNT_OUT_W'(r_count);
                r_sum_out   <= (32'(proper) > SUM_MAX) ? SUM_OUT_W'(SUM_MAX)
                                                       : SUM_OUT_W'(proper);
            end
        end
    end

    assign o_stat.n_zero   = r_n == '0;
    assign o_stat.sq_gt_n  = r_sq > SQ_W'(r_n);
    assign o_stat.div_busy = div_busy;
    assign o_stat.div_done = div_done;

    assign o_is_perfect         = r_perfect;
    assign o_is_harmonic        = r_harmonic;
    assign o_divisor_count      = r_count_out;
    assign o_proper_divisor_sum = r_sum_out;
    assign o_input_invalid      = r_invalid;

endmodule

// File: sv/phd_ctrl.sv
module phd_ctrl
    import phd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.n_zero) begin
                    n_state = S_OUT;
                end else if (i_stat.sq_gt_n) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.div_cand = 1'b1;
                    n_state        = S_DWAIT;
                end
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_TEST;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.div_mod = 1'b1;
                n_state       = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_harm = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_TEST))
        else $error("accepted beat did not start a test");
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside the output state");
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.div_cand || o_cmd.div_mod) |-> !i_stat.div_busy)
        else $error("divider started while busy");
`endif

endmodule

// File: sv/perfect_harmonic_divisor_test.sv
// Timing: a zero input skips the divisor scan; any other num runs one division per
// candidate up to floor(sqrt(num)) and one more for the harmonic check.
// Throughput: one number at a time; the next beat is taken in the cycle after the result is
// loaded, even while that result still waits on the output. Most of each candidate's time
// is spent in the serial divider, so the scan sets the rate.
// Reset: i_rst_n is synchronous and active low; it idles the controller and drops o_valid.
module perfect_harmonic_divisor_test
    import phd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [NUM_WIDTH-1:0]   i_num,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_is_perfect,
    output logic                   o_is_harmonic,
    output logic [COUNT_OUT_W-1:0] o_divisor_count,
    output logic [SUM_OUT_W-1:0]   o_proper_divisor_sum,
    output logic                   o_input_invalid
);

    // The controller walks candidates d = 1, 2, ... while d*d <= num. For each it runs
    // one restoring division of num by d; a zero remainder adds d and, unless d is the
    // exact square root, its cofactor num/d to the divisor sum and count. This pairing
    // finds every divisor that a scan of all candidates up to num would find.
    //
    // After the scan the datapath multiplies num by the divisor count and the same
    // divider reduces that product modulo sigma, the sum of all divisors. A zero
    // remainder marks a harmonic-divisor number. Perfect means the proper sum,
    // sigma minus num, equals num. Both checks use the full-width registers; only the
    // output fields saturate.
    //
    // The result is held in an output register, so a waiting result lets the block take
    // and classify the next number; only when that number has finished behind it does
    // the input stall until the output beat is taken.

    t_dp_cmd  cmd;
    t_dp_stat stat;

    phd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    phd_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_num                (i_num),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .o_is_perfect         (o_is_perfect),
        .o_is_harmonic        (o_is_harmonic),
        .o_divisor_count      (o_divisor_count),
        .o_proper_divisor_sum (o_proper_divisor_sum),
        .o_input_invalid      (o_input_invalid)
    );

endmodule

// File: test/perfect_harmonic_divisor_check.sv
// Watches both channels of the divisor classifier. It predicts the verdict for every
// number taken in and compares each result beat with the oldest prediction.
module perfect_harmonic_divisor_check
    import phd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_in_ready,
    input  logic [NUM_WIDTH-1:0]   i_num,
    input  logic                   i_out_valid,
    input  logic                   i_ready,
    input  logic                   i_is_perfect,
    input  logic                   i_is_harmonic,
    input  logic [COUNT_OUT_W-1:0] i_divisor_count,
    input  logic [SUM_OUT_W-1:0]   i_proper_divisor_sum,
    input  logic                   i_input_invalid,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_numbers_taken,
    output int                     o_perfect_seen,
    output int                     o_harmonic_seen,
    output int                     o_invalid_seen
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                   perfect;
        logic                   harmonic;
        logic [COUNT_OUT_W-1:0] count;
        logic [SUM_OUT_W-1:0]   proper_sum;
        logic                   invalid;
    } t_verdict;

    typedef struct {
        logic [NUM_WIDTH-1:0] num;
        t_verdict             verdict;
    } t_awaited;

    t_awaited awaited_q[$];
    t_awaited fresh;
    t_awaited oldest;
    t_verdict seen;

    int fail_count     = 0;
    int outstanding    = 0;
    int numbers_taken  = 0;
    int perfect_seen   = 0;
    int harmonic_seen  = 0;
    int invalid_seen   = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = outstanding;
    assign o_numbers_taken = numbers_taken;
    assign o_perfect_seen  = perfect_seen;
    assign o_harmonic_seen = harmonic_seen;
    assign o_invalid_seen  = invalid_seen;

    // Divisors are walked in pairs d and num/d up to the square root, which gives the
    // same count and sum as trying every candidate up to num.
    function automatic t_verdict classify_number(input logic [NUM_WIDTH-1:0] num);
        t_verdict        v;
        longint unsigned n;
        longint unsigned d;
        longint unsigned cofactor;
        longint unsigned count;
        longint unsigned sigma;
        longint unsigned proper;
        v = '0;
        n = num;
        if (n == 0) begin
            v.invalid = 1'b1;
            return v;
        end
        count = 0;
        sigma = 0;
        for (d = 1; d * d <= n; d++) begin
            if (n % d == 0) begin
                cofactor = n / d;
                count += 1;
                sigma += d;
                if (cofactor != d) begin
                    count += 1;
                    sigma += cofactor;
                end
            end
        end
        proper = sigma - n;
        v.perfect  = (proper == n);
        v.harmonic = ((n * count) % sigma) == 0;
        // Output fields saturate; the verdicts above use the exact values.
        v.count      = (count > COUNT_MAX) ? COUNT_OUT_W'(COUNT_MAX) : COUNT_OUT_W'(count);
        v.proper_sum = (proper > SUM_MAX) ? SUM_OUT_W'(SUM_MAX) : SUM_OUT_W'(proper);
        return v;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("[%0t] check error: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Results are matched before new numbers are queued, so a beat can never
            // pair with a number that arrived on the same edge.
            if (i_out_valid && i_ready) begin
                seen.perfect    = i_is_perfect;
                seen.harmonic   = i_is_harmonic;
                seen.count      = i_divisor_count;
                seen.proper_sum = i_proper_divisor_sum;
                seen.invalid    = i_input_invalid;
                if (awaited_q.size() == 0) begin
                    note_failure($sformatf(
                        {"result beat with no number outstanding:",
                         " perf=%0b harm=%0b cnt=%0d sum=%0d inv=%0b"},
                        seen.perfect, seen.harmonic, seen.count, seen.proper_sum,
                        seen.invalid));
                end else begin
                    oldest = awaited_q.pop_front();
                    if (seen.perfect !== oldest.verdict.perfect
                            || seen.harmonic !== oldest.verdict.harmonic
                            || seen.count !== oldest.verdict.count
                            || seen.proper_sum !== oldest.verdict.proper_sum
                            || seen.invalid !== oldest.verdict.invalid) begin
                        note_failure($sformatf(
                            {"num %0d: expected perf=%0b harm=%0b cnt=%0d sum=%0d inv=%0b,",
                             " got perf=%0b harm=%0b cnt=%0d sum=%0d inv=%0b"},
                            oldest.num, oldest.verdict.perfect, oldest.verdict.harmonic,
                            oldest.verdict.count, oldest.verdict.proper_sum,
                            oldest.verdict.invalid, seen.perfect, seen.harmonic, seen.count,
                            seen.proper_sum, seen.invalid));
                    end
                    perfect_seen  += oldest.verdict.perfect;
                    harmonic_seen += oldest.verdict.harmonic;
                    invalid_seen  += oldest.verdict.invalid;
                end
            end
            if (i_valid && i_in_ready) begin
                fresh.num     = i_num;
                fresh.verdict = classify_number(i_num);
                awaited_q.push_back(fresh);
                numbers_taken++;
            end
            outstanding = awaited_q.size();
        end
    end

endmodule

// File: test/testbench.sv
// Top level of the divisor classifier test. This module only produces stimulus and
// gives the verdict; all prediction and comparison lives in the checker beside the dut.
module testbench;
    import phd_pkg::*;

    // A 20-bit number near the top of the range needs far less than this, so a quiet
    // stretch of this length can only mean the block has hung.
    localparam int WATCHDOG_LIMIT = 200000;
    // Long output stall used to back the block up while numbers keep arriving.
    localparam int RX_HOLD_CYCLES = 3000;
    // Settles any stray beat after the drain.
    localparam int SETTLE_CYCLES  = 64;
    localparam int ITEMS_PER_PROFILE = 25;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [NUM_WIDTH-1:0]   i_num;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_is_perfect;
    logic                   o_is_harmonic;
    logic [COUNT_OUT_W-1:0] o_divisor_count;
    logic [SUM_OUT_W-1:0]   o_proper_divisor_sum;
    logic                   o_input_invalid;

    int fail_count;
    int pending;
    int numbers_taken;
    int perfect_seen;
    int harmonic_seen;
    int invalid_seen;

    // Idle percentages for each side, changed by the main sequence between profiles.
    int tx_idle_pct  = 17;
    int rx_idle_pct  = 82;
    // Set by the main sequence, cleared by the receiver once its long stall is over.
    bit rx_hold_req  = 1'b0;
    int quiet_cycles = 0;

    // Directed numbers: zero and one, small primes and composites, the perfect numbers
    // that fit, several harmonic-divisor numbers, multiply-perfect numbers, the all-ones
    // and top-bit-only inputs, the largest prime below 2^20 and a number with 240 divisors.
    int unsigned directed_nums[] = '{
        0, 1, 2, 3, 4, 6, 12, 28, 120, 140, 270, 496, 672, 1638, 8128, 30240,
        1023, 65537, 524288, 1048575, 1048573, 720720, 950976, 695520
    };

    perfect_harmonic_divisor_test dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_num                (i_num),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_is_perfect         (o_is_perfect),
        .o_is_harmonic        (o_is_harmonic),
        .o_divisor_count      (o_divisor_count),
        .o_proper_divisor_sum (o_proper_divisor_sum),
        .o_input_invalid      (o_input_invalid)
    );

    perfect_harmonic_divisor_check u_verdict_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .i_in_ready           (o_ready),
        .i_num                (i_num),
        .i_out_valid          (o_valid),
        .i_ready              (i_ready),
        .i_is_perfect         (o_is_perfect),
        .i_is_harmonic        (o_is_harmonic),
        .i_divisor_count      (o_divisor_count),
        .i_proper_divisor_sum (o_proper_divisor_sum),
        .i_input_invalid      (o_input_invalid),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_numbers_taken      (numbers_taken),
        .o_perfect_seen       (perfect_seen),
        .o_harmonic_seen      (harmonic_seen),
        .o_invalid_seen       (invalid_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver decides ready afresh each cycle. When a long stall is requested it
    // holds ready low throughout that stall, whatever the block is offering.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // The watchdog restarts on every accepted beat on either channel. Reaching the
    // limit means the block stopped taking numbers or stopped delivering results.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one number and returns on the edge where it is taken. Valid stays high on
    // return so back-to-back beats never lower and raise it in the same step; a gap,
    // when one is drawn, lowers it first and waits at least one edge.
    task automatic send_number(input logic [NUM_WIDTH-1:0] num);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid <= 1'b1;
        i_num   <= num;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stops offering and waits for every outstanding result. The first edge lets the
    // checker register the beat that was just accepted.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Most numbers are small so the run stays short; a few span the whole field so that
    // every input bit toggles and the long divisor walks are exercised too.
    function automatic logic [NUM_WIDTH-1:0] random_number();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            return NUM_WIDTH'($urandom);
        end else if (pick < 20) begin
            return NUM_WIDTH'($urandom_range(65535));
        end else if (pick < 30) begin
            return NUM_WIDTH'($urandom_range(63));
        end
        return NUM_WIDTH'($urandom_range(4095));
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_num   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed numbers under the first idling profile: sender mostly busy,
        // receiver mostly stalled.
        foreach (directed_nums[k]) begin
            send_number(NUM_WIDTH'(directed_nums[k]));
        end
        wait_for_results();

        repeat (ITEMS_PER_PROFILE) send_number(random_number());
        wait_for_results();

        // Second profile: the sender now idles most of the time and the receiver rarely.
        tx_idle_pct = 82;
        rx_idle_pct = 17;
        repeat (ITEMS_PER_PROFILE) send_number(random_number());
        wait_for_results();

        // Third profile: neither side idles. It opens with a long output stall while small
        // numbers keep coming, so one result sits on the output, the next one finishes
        // behind it and the block has to refuse further input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (6) send_number(NUM_WIDTH'($urandom_range(40, 1)));
        repeat (ITEMS_PER_PROFILE - 6) send_number(random_number());
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Classified %0d numbers under three idling profiles, a long output stall",
                 numbers_taken);
        $display("and drain pauses; %0d perfect, %0d harmonic-divisor, %0d zero inputs.",
                 perfect_seen, harmonic_seen, invalid_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d check errors, %0d results outstanding", fail_count, pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
